/* src/hrk_pkg.sv */
// shared types, constants and the usage-to-scancode table of the key event diff unit
package hrk_pkg;

  localparam int unsigned MOD_EVENTS = 6;

  // modifier byte bit positions and scancodes in emission order
  localparam logic [2:0] ModBit [MOD_EVENTS] = '{3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6};
  localparam logic [7:0] ModScan [MOD_EVENTS] = '{8'h1d, 8'h9d, 8'h2a, 8'h36, 8'h38, 8'hb8};

  typedef struct packed {
    logic       is_press;
    logic [7:0] scan;
    logic [6:0] ascii;
  } evt_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] scan;
    logic [6:0] ascii;
  } map_t;

  typedef struct packed {
    logic press_vld;
    evt_t press;
    logic rel_vld;
    evt_t rel;
  } lane_res_t;

  function automatic map_t key_lookup(input logic [7:0] usage);
    map_t m;
    m = '{hit: 1'b1, scan: 8'h00, ascii: 7'h00};
    unique case (usage)
      8'd4:  begin m.scan = 8'h1e; m.ascii = 7'h61; end
      8'd5:  begin m.scan = 8'h30; m.ascii = 7'h62; end
      8'd6:  begin m.scan = 8'h2e; m.ascii = 7'h63; end
      8'd7:  begin m.scan = 8'h20; m.ascii = 7'h64; end
      8'd8:  begin m.scan = 8'h12; m.ascii = 7'h65; end
      8'd9:  begin m.scan = 8'h21; m.ascii = 7'h66; end
      8'd10: begin m.scan = 8'h22; m.ascii = 7'h67; end
      8'd11: begin m.scan = 8'h23; m.ascii = 7'h68; end
      8'd12: begin m.scan = 8'h17; m.ascii = 7'h69; end
      8'd13: begin m.scan = 8'h24; m.ascii = 7'h6a; end
      8'd14: begin m.scan = 8'h25; m.ascii = 7'h6b; end
      8'd15: begin m.scan = 8'h26; m.ascii = 7'h6c; end
      8'd16: begin m.scan = 8'h32; m.ascii = 7'h6d; end
      8'd17: begin m.scan = 8'h31; m.ascii = 7'h6e; end
      8'd18: begin m.scan = 8'h18; m.ascii = 7'h6f; end
      8'd19: begin m.scan = 8'h19; m.ascii = 7'h70; end
      8'd20: begin m.scan = 8'h10; m.ascii = 7'h71; end
      8'd21: begin m.scan = 8'h13; m.ascii = 7'h72; end
      8'd22: begin m.scan = 8'h1f; m.ascii = 7'h73; end
      8'd23: begin m.scan = 8'h14; m.ascii = 7'h74; end
      8'd24: begin m.scan = 8'h16; m.ascii = 7'h75; end
      8'd25: begin m.scan = 8'h2f; m.ascii = 7'h76; end
      8'd26: begin m.scan = 8'h11; m.ascii = 7'h77; end
      8'd27: begin m.scan = 8'h2d; m.ascii = 7'h78; end
      8'd28: begin m.scan = 8'h15; m.ascii = 7'h79; end
      8'd29: begin m.scan = 8'h2c; m.ascii = 7'h7a; end
      8'd30: begin m.scan = 8'h02; m.ascii = 7'h31; end
      8'd31: begin m.scan = 8'h03; m.ascii = 7'h32; end
      8'd32: begin m.scan = 8'h04; m.ascii = 7'h33; end
      8'd33: begin m.scan = 8'h05; m.ascii = 7'h34; end
      8'd34: begin m.scan = 8'h06; m.ascii = 7'h35; end
      8'd35: begin m.scan = 8'h07; m.ascii = 7'h36; end
      8'd36: begin m.scan = 8'h08; m.ascii = 7'h37; end
      8'd37: begin m.scan = 8'h09; m.ascii = 7'h38; end
      8'd38: begin m.scan = 8'h0a; m.ascii = 7'h39; end
      8'd39: begin m.scan = 8'h0b; m.ascii = 7'h30; end
      8'd40: begin m.scan = 8'h1c; m.ascii = 7'h0d; end
      8'd41: begin m.scan = 8'h01; m.ascii = 7'h1b; end
      8'd42: begin m.scan = 8'h0e; m.ascii = 7'h08; end
      8'd43: begin m.scan = 8'h0f; m.ascii = 7'h09; end
      8'd44: begin m.scan = 8'h39; m.ascii = 7'h20; end
      8'd45: begin m.scan = 8'h0c; m.ascii = 7'h2d; end
      8'd46: begin m.scan = 8'h0d; m.ascii = 7'h3d; end
      8'd55: begin m.scan = 8'h34; m.ascii = 7'h2e; end
      8'd56: begin m.scan = 8'h35; m.ascii = 7'h2f; end
      8'd79: m.scan = 8'hcd;
      8'd80: m.scan = 8'hcb;
      8'd81: m.scan = 8'hd0;
      8'd82: m.scan = 8'hc8;
      8'd74: m.scan = 8'hc7;
      8'd77: m.scan = 8'hcf;
      8'd75: m.scan = 8'hc9;
      8'd78: m.scan = 8'hd1;
      8'd73: m.scan = 8'hd2;
      8'd76: m.scan = 8'hd3;
      default: m.hit = 1'b0;
    endcase
    return m;
  endfunction

endpackage

/* src/hid_report_key_event_diff_unit.sv */
// top level of the boot keyboard report to key event diff unit
// A report transfer carries the modifier byte and KEY_SLOTS usages; the unit compares it with
// the previous report combinationally across per-slot lanes and queues its events (modifier edges,
// then presses in slot order, then releases in previous-slot order). Events leave one per cycle
// while the output is not stalled, through a single output register, the last one flagged by
// tlast; the first event of a report passes the event buffer and then the output register. The
// next report is taken in the cycle its predecessor's last event moves into the output
// register, so s_axis_tready also depends on m_axis_tready in that cycle.
module hid_report_key_event_diff_unit #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // modifier_bits, key_usage_0 .. key_usage_(KEY_SLOTS-1)
  input  logic [(KEY_SLOTS+1)*8-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // scan_code, ascii_code, zero pad bit
  output logic [15:0]                  m_axis_tdata,
  // is_press
  output logic                         m_axis_tuser,
  // last_event
  output logic                         m_axis_tlast
);

  localparam int unsigned NumEvt = hrk_pkg::MOD_EVENTS + 2 * KEY_SLOTS;

  logic [7:0]                  mods;
  logic [KEY_SLOTS*8-1:0]      keys;
  logic [7:0]                  prev_mods_q;
  logic [KEY_SLOTS*8-1:0]      prev_keys_q;
  logic                        accept;
  logic                        busy;
  hrk_pkg::lane_res_t [KEY_SLOTS-1:0] lane_res;
  logic [NumEvt-1:0]           evt_vld;
  hrk_pkg::evt_t [NumEvt-1:0]  evts;
  hrk_pkg::evt_t               out_evt;

  assign mods          = s_axis_tdata[7:0];
  assign keys          = s_axis_tdata[(KEY_SLOTS+1)*8-1:8];
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hrk_lane #(
      .KEY_SLOTS(KEY_SLOTS)
    ) u_lane (
      .cur_key_i  (keys[8*g +: 8]),
      .prev_key_i (prev_keys_q[8*g +: 8]),
      .cur_keys_i (keys),
      .prev_keys_i(prev_keys_q),
      .res_o      (lane_res[g])
    );
  end

  always_comb begin
    for (int unsigned m = 0; m < hrk_pkg::MOD_EVENTS; m++) begin
      evt_vld[m] = mods[hrk_pkg::ModBit[m]] ^ prev_mods_q[hrk_pkg::ModBit[m]];
      evts[m]    = '{is_press: mods[hrk_pkg::ModBit[m]], scan: hrk_pkg::ModScan[m],
                     ascii: 7'h00};
    end
    for (int unsigned k = 0; k < KEY_SLOTS; k++) begin
      evt_vld[hrk_pkg::MOD_EVENTS + k]             = lane_res[k].press_vld;
      evts[hrk_pkg::MOD_EVENTS + k]                = lane_res[k].press;
      evt_vld[hrk_pkg::MOD_EVENTS + KEY_SLOTS + k] = lane_res[k].rel_vld;
      evts[hrk_pkg::MOD_EVENTS + KEY_SLOTS + k]    = lane_res[k].rel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mods_q <= '0;
      prev_keys_q <= '0;
    end else if (accept) begin
      prev_mods_q <= mods;
      prev_keys_q <= keys;
    end
  end

  hrk_merge #(
    .NUM_EVT(NumEvt)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .evt_vld_i (evt_vld),
    .evt_i     (evts),
    .busy_o    (busy),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .out_evt_o (out_evt),
    .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_evt.ascii, out_evt.scan};
  assign m_axis_tuser = out_evt.is_press;

endmodule

/* src/hrk_lane.sv */
// per-slot lane: press and release candidates of one key slot
module hrk_lane #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic [7:0]             cur_key_i,
  input  logic [7:0]             prev_key_i,
  input  logic [KEY_SLOTS*8-1:0] cur_keys_i,
  input  logic [KEY_SLOTS*8-1:0] prev_keys_i,
  output hrk_pkg::lane_res_t     res_o
);

  logic         seen_prev;
  logic         seen_cur;
  hrk_pkg::map_t press_map;
  hrk_pkg::map_t rel_map;

  always_comb begin
    seen_prev = 1'b0;
    seen_cur  = 1'b0;
    for (int unsigned j = 0; j < KEY_SLOTS; j++) begin
      seen_prev = seen_prev | (prev_keys_i[8*j +: 8] == cur_key_i);
      seen_cur  = seen_cur  | (cur_keys_i[8*j +: 8] == prev_key_i);
    end
  end

  assign press_map = hrk_pkg::key_lookup(cur_key_i);
  assign rel_map   = hrk_pkg::key_lookup(prev_key_i);

  assign res_o.press_vld = (cur_key_i != 8'h00) && !seen_prev && press_map.hit;
  assign res_o.press     = '{is_press: 1'b1, scan: press_map.scan, ascii: press_map.ascii};
  assign res_o.rel_vld   = (prev_key_i != 8'h00) && !seen_cur && rel_map.hit;
  assign res_o.rel       = '{is_press: 1'b0, scan: rel_map.scan, ascii: rel_map.ascii};

endmodule

/* src/hrk_merge.sv */
// merging stage: event buffer, lowest-first serializer and output register
module hrk_merge #(
  parameter int unsigned NUM_EVT = 18
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic [NUM_EVT-1:0]               evt_vld_i,
  input  hrk_pkg::evt_t [NUM_EVT-1:0]      evt_i,
  output logic                             busy_o,
  output logic                             out_vld_o,
  input  logic                             out_rdy_i,
  output hrk_pkg::evt_t                    out_evt_o,
  output logic                             out_last_o
);

  localparam int unsigned EvtW = $bits(hrk_pkg::evt_t);

  logic [NUM_EVT-1:0]          mask_q, mask_d;
  hrk_pkg::evt_t [NUM_EVT-1:0] evt_q;
  logic [NUM_EVT-1:0]          low;
  logic [EvtW-1:0]             sel;
  logic                        out_free;
  logic                        out_vld_q, out_vld_d;
  hrk_pkg::evt_t               out_evt_q;
  logic                        out_last_q;

  assign low      = mask_q & (~mask_q + NUM_EVT'(1));
  assign out_free = !out_vld_q || out_rdy_i;

  always_comb begin
    sel = '0;
    for (int unsigned i = 0; i < NUM_EVT; i++) begin
      sel = sel | (evt_q[i] & {EvtW{low[i]}});
    end
  end

  always_comb begin
    mask_d    = mask_q;
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = |mask_q;
      mask_d    = mask_q & ~low;
    end
    if (load_i) begin
      mask_d = evt_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mask_q    <= mask_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      evt_q <= evt_i;
    end
    if (out_free && (|mask_q)) begin
      out_evt_q  <= hrk_pkg::evt_t'(sel);
      out_last_q <= ((mask_q & ~low) == '0);
    end
  end

  // a new load is taken when the buffer is empty or its last queued event moves out this cycle
  assign busy_o     = (|(mask_q & ~low)) || ((|mask_q) && !out_free);
  assign out_vld_o  = out_vld_q;
  assign out_evt_o  = out_evt_q;
  assign out_last_o = out_last_q;

endmodule

/* src/hrk_checker.sv */
// port-level checker of the key event diff unit and its bind
module hrk_checker #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [(KEY_SLOTS+1)*8-1:0] s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [15:0]                m_axis_tdata,
  input logic                       m_axis_tuser,
  input logic                       m_axis_tlast
);

  // input side closes only after a report transfer
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("s_axis_tready fell without a report transfer");

  // the first event of a report shows only after its transfer
  a_valid_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("event appeared with no pending report");

  // a non-final event is always followed by another event
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("event run ended without tlast");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("stalled event transfer changed");

  // a waiting report stays on the input
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && !s_axis_tready) |=> (s_axis_tvalid && $stable(s_axis_tdata)))
    else $error("waiting report transfer changed");

endmodule

bind hid_report_key_event_diff_unit hrk_checker #(.KEY_SLOTS(KEY_SLOTS)) u_hrk_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the boot keyboard report to key event diff unit
module tb;

  localparam int SLOTS = 6;
  localparam int MOD_EDGES = 6;
  localparam int MAX_MAPPED_USAGE = 82;
  localparam int RANDOM_PER_PHASE = 32;
  localparam int DRAIN_CYCLES = 20;

  // modifier byte bits and scancodes in event order
  localparam int MOD_BIT [MOD_EDGES] = '{0, 4, 1, 5, 2, 6};
  localparam logic [7:0] MOD_SCAN [MOD_EDGES] = '{8'h1d, 8'h9d, 8'h2a, 8'h36, 8'h38, 8'hb8};

  // set-1 scancode per usage, zero where the usage is unmapped
  localparam logic [7:0] USAGE_SCAN [MAX_MAPPED_USAGE+1] = '{
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26, 8'h32,
    8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11, 8'h2d, 8'h15, 8'h2c,
    8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b,
    8'h1c, 8'h01, 8'h0e, 8'h0f, 8'h39, 8'h0c, 8'h0d,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h34, 8'h35,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hd2, 8'hc7, 8'hc9, 8'hd3, 8'hcf, 8'hd1, 8'hcd, 8'hcb, 8'hd0, 8'hc8
  };

  // sender idle and receiver stall percentages per phase
  localparam int PHASE_IDLE [4] = '{0, 81, 0, 18};
  localparam int PHASE_STALL [4] = '{0, 0, 81, 18};

  typedef struct packed {
    logic       is_press;
    logic [7:0] scan;
    logic [6:0] ascii;
    logic       last;
  } key_event_t;

  typedef logic [0:SLOTS-1][7:0] key_slots_t;

  typedef struct packed {
    logic       typed;
    logic       one_event;
    key_event_t typed_ev;
    logic [7:0] mods;
    key_slots_t keys;
  } report_row_t;

  localparam key_event_t NO_EVENT = '0;

  localparam int DIRECTED_LEN = 21;
  localparam report_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{1'b1, 1'b0, NO_EVENT, 8'h00, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{1'b1, 1'b1, '{1'b1, 8'h1d, 7'h00, 1'b1}, 8'h01, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{1'b0, 1'b0, NO_EVENT, 8'hff, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{1'b0, 1'b0, NO_EVENT, 8'h00, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    // unused modifier bits only
    '{1'b1, 1'b0, NO_EVENT, 8'h88, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{1'b1, 1'b1, '{1'b1, 8'h1e, 7'h61, 1'b1}, 8'h88, '{8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{1'b0, 1'b0, NO_EVENT, 8'h88, '{8'd5, 8'd6, 8'd7, 8'd79, 8'd82, 8'd44}},
    // unmapped usages press nothing
    '{1'b0, 1'b0, NO_EVENT, 8'h88, '{8'hff, 8'h01, 8'h02, 8'h03, 8'h80, 8'h39}},
    '{1'b1, 1'b0, NO_EVENT, 8'h08, '{8'hff, 8'h01, 8'h02, 8'h03, 8'h80, 8'h39}},
    // repeated usage, one event per slot
    '{1'b0, 1'b0, NO_EVENT, 8'h00, '{8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd0}},
    '{1'b0, 1'b0, NO_EVENT, 8'h00, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{1'b0, 1'b0, NO_EVENT, 8'h00, '{8'd4, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0}},
    // keys moving between slots
    '{1'b1, 1'b0, NO_EVENT, 8'h00, '{8'd0, 8'd0, 8'd5, 8'd4, 8'd0, 8'd0}},
    '{1'b0, 1'b0, NO_EVENT, 8'h00, '{8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35}},
    // full load of events both ways
    '{1'b0, 1'b0, NO_EVENT, 8'h77, '{8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41}},
    '{1'b0, 1'b0, NO_EVENT, 8'h00, '{8'd42, 8'd43, 8'd45, 8'd46, 8'd55, 8'd56}},
    '{1'b0, 1'b0, NO_EVENT, 8'h00, '{8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78}},
    '{1'b0, 1'b0, NO_EVENT, 8'hff, '{8'd79, 8'd80, 8'd81, 8'd82, 8'hff, 8'hff}},
    '{1'b0, 1'b0, NO_EVENT, 8'h00, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
    '{1'b1, 1'b1, '{1'b1, 8'h2c, 7'h7a, 1'b1}, 8'h00, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd29}},
    '{1'b1, 1'b1, '{1'b0, 8'h2c, 7'h7a, 1'b1}, 8'h00, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [(SLOTS+1)*8-1:0] s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [15:0]            m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  key_event_t pending_events[$];
  key_event_t report_events[$];
  logic [7:0] held_mods = 8'h00;
  key_slots_t held_keys = '0;
  int         mismatch_count = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;

  hid_report_key_event_diff_unit #(
    .KEY_SLOTS(SLOTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] usage_scan(input logic [7:0] usage);
    if (usage > MAX_MAPPED_USAGE) return 8'h00;
    return USAGE_SCAN[usage];
  endfunction

  function automatic logic [6:0] usage_ascii(input logic [7:0] usage);
    if (usage >= 8'd4 && usage <= 8'd29) return 7'(usage - 8'd4 + 8'h61);
    if (usage >= 8'd30 && usage <= 8'd38) return 7'(usage - 8'd30 + 8'h31);
    case (usage)
      8'd39: return 7'h30;
      8'd40: return 7'h0d;
      8'd41: return 7'h1b;
      8'd42: return 7'h08;
      8'd43: return 7'h09;
      8'd44: return 7'h20;
      8'd45: return 7'h2d;
      8'd46: return 7'h3d;
      8'd55: return 7'h2e;
      8'd56: return 7'h2f;
      default: return 7'h00;
    endcase
  endfunction

  function automatic logic slots_hold(input key_slots_t slots, input logic [7:0] usage);
    for (int i = 0; i < SLOTS; i++) begin
      if (slots[i] == usage) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_key_event(input logic press, input logic [7:0] usage);
    key_event_t ev;
    if (usage_scan(usage) != 8'h00) begin
      ev = '{press, usage_scan(usage), usage_ascii(usage), 1'b0};
      report_events.push_back(ev);
    end
  endfunction

  // events caused by one report, then the report becomes the held one
  function automatic void diff_report(input logic [7:0] mods, input key_slots_t keys);
    key_event_t ev;
    report_events.delete();
    for (int i = 0; i < MOD_EDGES; i++) begin
      if (mods[MOD_BIT[i]] != held_mods[MOD_BIT[i]]) begin
        ev = '{mods[MOD_BIT[i]], MOD_SCAN[i], 7'h00, 1'b0};
        report_events.push_back(ev);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (keys[i] != 8'h00 && !slots_hold(held_keys, keys[i])) add_key_event(1'b1, keys[i]);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (held_keys[i] != 8'h00 && !slots_hold(keys, held_keys[i]))
        add_key_event(1'b0, held_keys[i]);
    end
    if (report_events.size() > 0) report_events[report_events.size()-1].last = 1'b1;
    held_mods = mods;
    held_keys = keys;
  endfunction

  function automatic logic [7:0] pick_usage();
    int idx;
    if ($urandom_range(99) >= 85) return 8'($urandom_range(255));
    idx = $urandom_range(54);
    if (idx < 43) return 8'(4 + idx);
    if (idx < 45) return 8'(55 + idx - 43);
    return 8'(73 + idx - 45);
  endfunction

  task automatic send_report(input logic [7:0] mods, input key_slots_t keys);
    logic [(SLOTS+1)*8-1:0] word;
    word[7:0] = mods;
    for (int i = 0; i < SLOTS; i++) word[8*(i+1) +: 8] = keys[i];
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_events.size() > 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: event transfer with none expected: press=%0b tdata=%04h last=%0b",
                   $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser !== want.is_press || m_axis_tdata[7:0] !== want.scan ||
            m_axis_tdata[14:8] !== want.ascii || m_axis_tdata[15] !== 1'b0 ||
            m_axis_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: event mismatch: expected press=%0b scan=%02h ascii=%02h last=%0b,",
                      " got press=%0b scan=%02h ascii=%02h pad=%0b last=%0b"},
                     $realtime, want.is_press, want.scan, want.ascii, want.last,
                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[14:8], m_axis_tdata[15],
                     m_axis_tlast);
        end
      end
    end
  end

  initial begin
    report_row_t row;
    logic [7:0]  mods;
    key_slots_t  keys;
    int          pick;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIRECTED_LEN; r++) begin
      row = DIRECTED_ROWS[r];
      send_report(row.mods, row.keys);
      diff_report(row.mods, row.keys);
      if (row.typed) begin
        if (row.one_event) pending_events.push_back(row.typed_ev);
      end else begin
        foreach (report_events[i]) pending_events.push_back(report_events[i]);
      end
    end
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct = PHASE_IDLE[p];
      stall_pct = PHASE_STALL[p];
      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(99) < 10) begin
          // noise report
          mods = 8'($urandom_range(255));
          for (int i = 0; i < SLOTS; i++) keys[i] = 8'($urandom_range(255));
        end else begin
          // typing: flip some modifiers, keep, drop or add keys
          mods = held_mods;
          for (int b = 0; b < 8; b++) begin
            if ($urandom_range(99) < 20) mods[b] = ~mods[b];
          end
          for (int i = 0; i < SLOTS; i++) begin
            pick = $urandom_range(99);
            if (pick < 55) keys[i] = held_keys[i];
            else if (pick < 75) keys[i] = 8'h00;
            else keys[i] = pick_usage();
          end
        end
        send_report(mods, keys);
        diff_report(mods, keys);
        foreach (report_events[i]) pending_events.push_back(report_events[i]);
      end
      wait_drained();
    end

    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("hid_report_key_event_diff_unit: match");
    end else begin
      $display("hid_report_key_event_diff_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("hid_report_key_event_diff_unit: mismatch");
    $finish;
  end

endmodule

/* sim.f */
src/hrk_pkg.sv
src/hrk_lane.sv
src/hrk_merge.sv
src/hid_report_key_event_diff_unit.sv
src/hrk_checker.sv
tb/tb.sv
